/* design/dred_pkg.sv */
// Shared types and constants for the debounced rotary encoder decoder.
`timescale 1ns / 1ps

package dred_pkg;

	localparam int COUNT_WIDTH     = 32;
	localparam int TIME_WIDTH      = 64;
	localparam int IN_TIME_WIDTH   = 64;
	localparam int TOTAL_WIDTH     = 32;
	localparam int SETTLE_WIDTH    = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int CODE_WIDTH      = 2;
	localparam int CMP_WIDTH       = (TIME_WIDTH > SETTLE_WIDTH) ? TIME_WIDTH : SETTLE_WIDTH;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_TIME = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A_ACTIVE    = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B_ACTIVE    = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_DIR  = 2'd3;

	localparam logic [CODE_WIDTH-1:0] CODE_IDLE = 2'd0;
	localparam logic [CODE_WIDTH-1:0] CODE_CCW  = 2'd1;
	localparam logic [CODE_WIDTH-1:0] CODE_CW   = 2'd2;

	localparam logic [SETTLE_WIDTH-1:0] SETTLE_RESET = 32'd1000;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TIME_WIDTH-1:0]  time_t;
	typedef logic [CODE_WIDTH-1:0]  code_t;

	typedef struct packed {
		logic [IN_TIME_WIDTH-1:0] time_us;
		logic                     pin_a;
		logic                     pin_b;
	} dred_in_t;

	typedef struct packed {
		logic                   step_cw;
		logic                   step_ccw;
		logic [TOTAL_WIDTH-1:0] cw_total;
		logic [TOTAL_WIDTH-1:0] ccw_total;
	} dred_out_t;

	typedef struct packed {
		logic [SETTLE_WIDTH-1:0] settle_time_us;
		logic                    a_active_high;
		logic                    b_active_high;
		logic                    invert_direction;
	} dred_cfg_t;

	// One polled sample after polarity correction
	typedef struct packed {
		time_t now;
		code_t code;
	} dred_sample_t;

endpackage

/* design/dred_in_stage.sv */
// Input register: capture a poll request and form the polarity-corrected pin code.
`timescale 1ns / 1ps

module dred_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  drain,
	input  dred_pkg::dred_in_t    in_data,
	input  dred_pkg::dred_cfg_t   cfg,
	output logic                  valid_s1,
	output dred_pkg::dred_sample_t sample_s1
);
	import dred_pkg::*;

	logic lev_a;
	logic lev_b;

	// Inverted pins read active low
	assign lev_a = in_data.pin_a ^ ~cfg.a_active_high;
	assign lev_b = in_data.pin_b ^ ~cfg.b_active_high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1.now  <= TIME_WIDTH'(in_data.time_us);
			sample_s1.code <= {lev_a, lev_b};
		end
	end

endmodule

/* design/dred_core.sv */
// Debounce state, settle timer compare and detent counters.
`timescale 1ns / 1ps

module dred_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  dred_pkg::dred_sample_t sample_s1,
	input  dred_pkg::dred_cfg_t    cfg,
	output dred_pkg::dred_out_t    result
);
	import dred_pkg::*;

	code_t  current_code_q;
	code_t  last_code_q;
	logic   accepted_q;
	time_t  change_time_q;
	count_t cw_count_q;
	count_t ccw_count_q;

	time_t  elapsed;
	logic   same_code;
	logic   settle_done;
	logic   take_code;
	logic   detent;
	logic   is_cw;
	logic   pulse_cw;
	logic   pulse_ccw;
	count_t cw_next;
	count_t ccw_next;

	always_comb begin
		same_code   = (sample_s1.code == current_code_q);
		elapsed     = sample_s1.now - change_time_q;
		settle_done = (CMP_WIDTH'(elapsed) >= CMP_WIDTH'(cfg.settle_time_us));
		take_code   = same_code && !accepted_q && settle_done;
		detent      = take_code && (last_code_q == CODE_IDLE) &&
			((sample_s1.code == CODE_CCW) || (sample_s1.code == CODE_CW));
		is_cw       = (sample_s1.code == CODE_CW) ^ cfg.invert_direction;
		pulse_cw    = detent && is_cw;
		pulse_ccw   = detent && !is_cw;
		cw_next     = cw_count_q + count_t'(pulse_cw);
		ccw_next    = ccw_count_q + count_t'(pulse_ccw);

		result.step_cw   = pulse_cw;
		result.step_ccw  = pulse_ccw;
		result.cw_total  = TOTAL_WIDTH'(cw_next);
		result.ccw_total = TOTAL_WIDTH'(ccw_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_code_q <= CODE_IDLE;
			last_code_q    <= CODE_IDLE;
			accepted_q     <= 1'b0;
			change_time_q  <= '0;
			cw_count_q     <= '0;
			ccw_count_q    <= '0;
		end else if (fire) begin
			cw_count_q  <= cw_next;
			ccw_count_q <= ccw_next;
			if (!same_code) begin
				// restart the settle timer on any code change
				current_code_q <= sample_s1.code;
				accepted_q     <= 1'b0;
				change_time_q  <= sample_s1.now;
			end else if (take_code) begin
				accepted_q  <= 1'b1;
				last_code_q <= sample_s1.code;
			end
		end
	end

endmodule

/* design/dred_out_stage.sv */
// Result register: hold a finished result until the consumer takes it.
`timescale 1ns / 1ps

module dred_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                out_ready,
	input  dred_pkg::dred_out_t result,
	output logic                out_valid,
	output dred_pkg::dred_out_t out_data
);
	import dred_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= result;
		end
	end

endmodule

/* design/debounced_rotary_encoder_decoder.sv */
// Top level of the debounced rotary encoder decoder: handshake, config registers, stages.
`timescale 1ns / 1ps

//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data      | one poll request: time_us, pin_a/b
//  out     | out_valid, out_ready, out_data   | one result per poll: pulses, totals
//  cfg     | cfg_we, cfg_index, cfg_wdata     | register write, no wait, no read-back
//
//  A result is registered after its request is accepted: input register,
//  then the settle compare (64-bit subtract and compare) into the result register.
//  Throughput is one request per cycle while the output does not stall; the state update for a poll completes in
//  the cycle it moves from the input register to the result register.
//  Reset clears control state and the debounce state; settle time resets to 1000.
//  An output stall holds the result register and then the input register.

module debounced_rotary_encoder_decoder (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  dred_pkg::dred_in_t                       in_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output dred_pkg::dred_out_t                      out_data,
	input  logic                                     cfg_we,
	input  logic [dred_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [dred_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata
);
	import dred_pkg::*;

	dred_cfg_t    cfg_q;
	logic         valid_s1;
	dred_sample_t sample_s1;
	dred_out_t    result;
	logic         advance;
	logic         fire;
	logic         load_in;

	// Configuration registers; the user must write them only while the block is idle (the block does not enforce it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_time_us   <= SETTLE_RESET;
			cfg_q.a_active_high    <= 1'b0;
			cfg_q.b_active_high    <= 1'b0;
			cfg_q.invert_direction <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE_TIME: begin
					cfg_q.settle_time_us <= SETTLE_WIDTH'(cfg_wdata);
				end
				REG_A_ACTIVE: begin
					cfg_q.a_active_high <= cfg_wdata[0];
				end
				REG_B_ACTIVE: begin
					cfg_q.b_active_high <= cfg_wdata[0];
				end
				REG_INVERT_DIR: begin
					cfg_q.invert_direction <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// The result register can take a new result when empty or being drained
	assign advance  = !out_valid || out_ready;
	assign fire     = valid_s1 && advance;
	// The input register frees up whenever its request moves on
	assign in_ready = !valid_s1 || advance;
	assign load_in  = in_valid && in_ready;

	dred_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_in),
		.drain     (fire),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	dred_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.sample_s1 (sample_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	dred_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.out_ready (out_ready),
		.result    (result),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A poll never counts a detent in both directions
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.step_cw && out_data.step_ccw))
		else $error("both step pulses set on one result");

	// Backpressure reaches the input only when both registers are full and stalled
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a full pipeline");

	// A request that leaves the input register shows up as a result next cycle
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result lost after stage advance");

	// The input register empties only by handing its request on
	a_s1_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register dropped a request");

endmodule

/* dv/debounced_rotary_encoder_decoder_tb.sv */
// Self-checking testbench for the debounced rotary encoder decoder.
`timescale 1ns / 1ps

module debounced_rotary_encoder_decoder_tb;
	import dred_pkg::*;

	// Run length guard and the quiet time allowed after the last result
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;

	// The fourth quadrature code, both channels active
	localparam code_t CODE_BOTH = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	dred_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	dred_out_t out_data;
	logic                       cfg_we    = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

	debounced_rotary_encoder_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the configuration registers, at their reset values
	logic [SETTLE_WIDTH-1:0] settle_us = SETTLE_RESET;
	logic                    a_hi      = 1'b0;
	logic                    b_hi      = 1'b0;
	logic                    dir_swap  = 1'b0;

	// Shadow of the debounce state and the detent counters
	code_t  cur_code  = CODE_IDLE;
	code_t  last_acc  = CODE_IDLE;
	logic   acc_flag  = 1'b0;
	time_t  chg_time  = '0;
	count_t cw_cnt    = '0;
	count_t ccw_cnt   = '0;

	// Results owed by the block, oldest first
	dred_out_t expected_results[$];

	int error_count   = 0;
	int cycle_count   = 0;
	// Idling switches for each side and a one-shot long hold-off of the receiver
	bit send_idle     = 1'b1;
	bit recv_idle     = 1'b1;
	int hold_request  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Guard the run against a hung handshake
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL debounced_rotary_encoder_decoder");
		$finish;
	end

	// Predict the result of one poll and advance the shadow state.
	// A new code restarts the settle timer; a code that has held long enough
	// is accepted once, and only an accepted 1 or 2 right after an accepted 0
	// counts a detent. The elapsed time wraps at the time width, so a clock
	// that wraps or steps backwards simply yields a large difference.
	function automatic dred_out_t decode_poll(input dred_in_t req);
		code_t     code;
		time_t     elapsed;
		dred_out_t res;
		logic      is_cw;
		code = {req.pin_a ^ ~a_hi, req.pin_b ^ ~b_hi};
		res = '0;
		if (code == cur_code) begin
			elapsed = req.time_us - chg_time;
			if (!acc_flag && elapsed >= time_t'(settle_us)) begin
				acc_flag = 1'b1;
				if (last_acc == CODE_IDLE && (code == CODE_CCW || code == CODE_CW)) begin
					is_cw = (code == CODE_CW) ^ dir_swap;
					if (is_cw) begin
						cw_cnt = cw_cnt + 1'b1;
						res.step_cw = 1'b1;
					end else begin
						ccw_cnt = ccw_cnt + 1'b1;
						res.step_ccw = 1'b1;
					end
				end
				last_acc = code;
			end
		end else begin
			cur_code = code;
			acc_flag = 1'b0;
			chg_time = req.time_us;
		end
		res.cw_total  = cw_cnt;
		res.ccw_total = ccw_cnt;
		return res;
	endfunction

	function automatic int draw_gap(input bit enable);
		return enable ? $urandom_range(0, 4) : 0;
	endfunction

	// Offer one poll request after a random gap; hold valid and payload until
	// accepted, then log the predicted result. Valid stays high when the next
	// request follows without a gap.
	task automatic send_poll(input dred_in_t req);
		int gap;
		gap = draw_gap(send_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(decode_poll(req));
	endtask

	// Poll with raw pin levels that decode to the given code under the
	// present polarity settings.
	task automatic send_code(input time_t now, input code_t code);
		dred_in_t req;
		req.time_us = now;
		req.pin_a   = code[1] ^ ~a_hi;
		req.pin_b   = code[0] ^ ~b_hi;
		send_poll(req);
	endtask

	// Drop valid and wait until every owed result has arrived, then let the
	// pipeline settle before anything touches the registers.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Write one register; the block must be idle. Drop the enable again after
	// the write so back-to-back writes never touch cfg_we twice in one step.
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
	                         input logic [CFG_DATA_WIDTH-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SETTLE_TIME: settle_us = data;
			REG_A_ACTIVE:    a_hi      = data[0];
			REG_B_ACTIVE:    b_hi      = data[0];
			REG_INVERT_DIR:  dir_swap  = data[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [SETTLE_WIDTH-1:0] settle, input logic a_pol,
	                         input logic b_pol, input logic swap);
		write_reg(REG_SETTLE_TIME, settle);
		write_reg(REG_A_ACTIVE, {{(CFG_DATA_WIDTH-1){1'b0}}, a_pol});
		write_reg(REG_B_ACTIVE, {{(CFG_DATA_WIDTH-1){1'b0}}, b_pol});
		write_reg(REG_INVERT_DIR, {{(CFG_DATA_WIDTH-1){1'b0}}, swap});
	endtask

	// Receiver: check each result against the oldest prediction, then draw a
	// stall for the next one. A posted hold-off request overrides the stall
	// and is counted down here, while the sender keeps offering requests.
	initial begin
		int stall_left;
		int hold_left;
		dred_out_t want;
		stall_left = 0;
		hold_left  = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing owed, actual %h", $time, out_data);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.step_cw !== want.step_cw) begin
						$display("%0t: step_cw expected %h actual %h",
						         $time, want.step_cw, out_data.step_cw);
						error_count++;
					end
					if (out_data.step_ccw !== want.step_ccw) begin
						$display("%0t: step_ccw expected %h actual %h",
						         $time, want.step_ccw, out_data.step_ccw);
						error_count++;
					end
					if (out_data.cw_total !== want.cw_total) begin
						$display("%0t: cw_total expected %h actual %h",
						         $time, want.cw_total, out_data.cw_total);
						error_count++;
					end
					if (out_data.ccw_total !== want.ccw_total) begin
						$display("%0t: ccw_total expected %h actual %h",
						         $time, want.ccw_total, out_data.ccw_total);
						error_count++;
					end
				end
				stall_left = draw_gap(recv_idle);
			end
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Reset values: 1000 us settle, both pins inverted, normal direction.
	// Walk idle -> ccw -> both -> cw -> idle -> cw, with polls that come too
	// early, polls that repeat an accepted code, and a detent that must not
	// count because the previous accepted code was not idle.
	task automatic test_reset_values;
		send_code(64'd0,    CODE_IDLE);
		send_code(64'd999,  CODE_IDLE);
		send_code(64'd1000, CODE_IDLE);
		send_code(64'd1100, CODE_CCW);
		send_code(64'd2100, CODE_CCW);
		send_code(64'd2200, CODE_BOTH);
		send_code(64'd3300, CODE_BOTH);
		send_code(64'd3400, CODE_CW);
		send_code(64'd4400, CODE_CW);
		send_code(64'd4500, CODE_IDLE);
		send_code(64'd5500, CODE_IDLE);
		send_code(64'd5600, CODE_CW);
		send_code(64'd6600, CODE_CW);
		send_code(64'd6601, CODE_CW);
		drain();
	endtask

	// Zero settle time with both pins active high and the direction swapped:
	// the first repeat of a code accepts it.
	task automatic test_zero_settle_swapped;
		write_all('0, 1'b1, 1'b1, 1'b1);
		send_code(64'd10, CODE_IDLE);
		send_code(64'd10, CODE_IDLE);
		send_code(64'd11, CODE_CW);
		send_code(64'd11, CODE_CW);
		send_code(64'd12, CODE_IDLE);
		send_code(64'd12, CODE_IDLE);
		send_code(64'd13, CODE_CCW);
		send_code(64'd13, CODE_CCW);
		drain();
	endtask

	// Largest settle time at its boundary, a wrapping clock, and a clock that
	// steps backwards, with the all-ones time value.
	task automatic test_time_edges;
		write_all('1, 1'b0, 1'b1, 1'b0);
		send_code(64'd0,             CODE_IDLE);
		send_code(64'h0_FFFF_FFFE,   CODE_IDLE);
		send_code(64'h0_FFFF_FFFF,   CODE_IDLE);
		drain();
		write_reg(REG_SETTLE_TIME, 32'd15);
		send_code(64'hFFFF_FFFF_FFFF_FFF8, CODE_CW);
		send_code(64'd6,             CODE_CW);
		send_code(64'd7,             CODE_CW);
		send_code(64'd5000,          CODE_IDLE);
		send_code(64'd4000,          CODE_IDLE);
		send_code(64'hFFFF_FFFF_FFFF_FFFF, CODE_CCW);
		send_code(64'h8000_0000_0000_0000, CODE_CCW);
		drain();
	endtask

	// Hold the receiver off for a long stretch while requests keep coming
	// back to back, so the block fills and stalls its input.
	task automatic test_backpressure;
		send_idle = 1'b0;
		write_all(32'd3, 1'b1, 1'b0, 1'b0);
		hold_request = 300;
		random_turns(60);
		drain();
		send_idle = 1'b1;
	endtask

	// Mostly well-formed detent walks with random timing: each new code may
	// bounce against the old one, then is polled until it settles. The rest
	// is noise on the pins and random jumps of the clock.
	task automatic random_turns(input int n_polls);
		code_t gray_seq[4];
		time_t now;
		time_t short_dt;
		time_t long_dt;
		int    sent;
		int    pick;
		int    pos;
		int    prev_pos;
		bit    fwd;
		gray_seq[0] = CODE_IDLE;
		gray_seq[1] = CODE_CCW;
		gray_seq[2] = CODE_BOTH;
		gray_seq[3] = CODE_CW;
		now  = {$urandom, $urandom};
		sent = 0;
		pos  = 0;
		fwd  = $urandom_range(0, 1);
		while (sent < n_polls) begin
			short_dt = (settle_us == 0) ? time_t'(0) : time_t'($urandom_range(0, settle_us - 1));
			long_dt  = time_t'(settle_us) + time_t'($urandom_range(0, 5));
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 9) == 0) fwd = ~fwd;
				prev_pos = pos;
				pos = fwd ? (pos + 1) % 4 : (pos + 3) % 4;
				repeat ($urandom_range(0, 2)) begin
					send_code(now, gray_seq[pos]);
					now += short_dt;
					send_code(now, gray_seq[prev_pos]);
					now += short_dt;
					sent += 2;
				end
				send_code(now, gray_seq[pos]);
				now += ($urandom_range(0, 4) == 0) ? short_dt : long_dt;
				send_code(now, gray_seq[pos]);
				sent += 2;
				if ($urandom_range(0, 2) == 0) begin
					now += time_t'($urandom_range(0, 3));
					send_code(now, gray_seq[pos]);
					sent++;
				end
			end else if (pick < 90) begin
				now += time_t'($urandom_range(0, 3));
				send_code(now, code_t'($urandom_range(0, 3)));
				sent++;
			end else begin
				now = {$urandom, $urandom};
				send_code(now, gray_seq[pos]);
				sent++;
			end
		end
	endtask

	// Several random phases, each with its own settings: extreme and typical
	// settle times, random polarities and direction, and varied idling.
	task automatic test_random_phases;
		logic [SETTLE_WIDTH-1:0] settle;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: settle = '0;
				1: settle = $urandom_range(1, 20);
				2: settle = SETTLE_RESET;
				3: settle = $urandom;
				4: settle = '1;
				default: settle = $urandom_range(0, 8);
			endcase
			send_idle = (phase != 1);
			recv_idle = (phase != 1) && (phase != 3);
			write_all(settle, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
			random_turns(310);
			drain();
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		// Hold reset at the start, then release once for the whole run
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_zero_settle_swapped();
		test_time_edges();
		test_backpressure();
		test_random_phases();

		drain();
		if (error_count == 0) begin
			$display("PASS debounced_rotary_encoder_decoder");
		end else begin
			$display("FAIL debounced_rotary_encoder_decoder");
		end
		$finish;
	end

endmodule
